/* rtl/json_string_escaper_macros.svh */
// Assertion macros shared by the escaper modules
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// clocked check, off while reset is held
`define JSE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("escaper check failed");

// implication checked on every cycle
`define JSE_ASSERT_IMP(label, cond, prop) \
    `JSE_ASSERT(label, (cond) |-> (prop))

`endif

/* rtl/jse_pkg.sv */
// Types, codes and helpers shared by the JSON string escaper
package jse_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       error;
    } t_out_item;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] CFG_IDX_UNICODE = 2'd0;
    localparam logic [1:0] CFG_IDX_SLASHES = 2'd1;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_PAIR = 2'd1,
        OP_HEX  = 2'd2,
        OP_RAW  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        err;
        logic [3:0]  len;
        logic [31:0] data;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    localparam logic [19:0] SUPP_BASE = 20'h10000;
    localparam logic [5:0]  HIGH_SURR = 6'b110110;
    localparam logic [5:0]  LOW_SURR  = 6'b110111;

    localparam logic [3:0] LEN_CHAR  = 4'd1;
    localparam logic [3:0] LEN_PAIR  = 4'd2;
    localparam logic [3:0] LEN_HEX   = 4'd6;
    localparam logic [3:0] LEN_SURR  = 4'd12;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

/* rtl/jse_front.sv */
// Front part: accepts items, tracks UTF-8 sequences, issues output jobs
module jse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  jse_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic               i_cfg_data,
    output logic               o_push,
    output jse_pkg::t_job      o_job
);

    logic        r_esc_unicode, r_esc_slashes;
    logic [1:0]  r_exp, n_exp;
    logic [2:0]  r_len, n_len;
    logic [21:0] r_acc, n_acc;
    logic [7:0]  r_held [3];
    logic        held_we;
    logic [1:0]  held_idx;

    logic [7:0]  c;
    logic [21:0] acc_n;
    logic [19:0] v20;
    logic [2:0]  pos;

    assign c     = i_item.byte_value;
    assign acc_n = {r_acc[15:0], c[5:0]};
    assign v20   = acc_n[19:0] - jse_pkg::SUPP_BASE;
    assign pos   = r_len - {1'b0, r_exp};

    always_comb begin
        o_push   = 1'b0;
        o_job    = '{op: jse_pkg::OP_CHAR, err: 1'b0, len: jse_pkg::LEN_CHAR,
                     data: 32'h0};
        n_exp    = r_exp;
        n_len    = r_len;
        n_acc    = r_acc;
        held_we  = 1'b0;
        held_idx = pos[1:0];
        if (i_accept) begin
            unique case (i_item.kind)
                jse_pkg::KIND_START: begin
                    n_exp  = 2'd0;
                    n_len  = 3'd0;
                    n_acc  = 22'h0;
                    o_push = 1'b1;
                    o_job.data[7:0] = jse_pkg::CH_QUOTE;
                end
                jse_pkg::KIND_END: begin
                    o_push = 1'b1;
                    if (r_exp != 2'd0) begin
                        n_exp     = 2'd0;
                        n_len     = 3'd0;
                        n_acc     = 22'h0;
                        o_job.err = 1'b1;
                        o_job.data[7:0] = jse_pkg::CH_NUL;
                    end else begin
                        o_job.data[7:0] = jse_pkg::CH_QUOTE;
                    end
                end
                jse_pkg::KIND_BYTE: begin
                    if (r_exp != 2'd0) begin
                        n_acc = acc_n;
                        if (r_exp == 2'd1) begin
                            o_push = 1'b1;
                            n_exp  = 2'd0;
                            n_len  = 3'd0;
                            n_acc  = 22'h0;
                            if (r_esc_unicode) begin
                                o_job.op = jse_pkg::OP_HEX;
                                if (r_len == 3'd4) begin
                                    o_job.len  = jse_pkg::LEN_SURR;
                                    o_job.data = {jse_pkg::HIGH_SURR, v20[19:10],
                                                  jse_pkg::LOW_SURR, v20[9:0]};
                                end else begin
                                    o_job.len  = jse_pkg::LEN_HEX;
                                    o_job.data = {16'h0, acc_n[15:0]};
                                end
                            end else begin
                                o_job.op  = jse_pkg::OP_RAW;
                                o_job.len = {1'b0, r_len};
                                priority if (r_len == 3'd2) begin
                                    o_job.data = {r_held[0], c, 16'h0};
                                end else if (r_len == 3'd3) begin
                                    o_job.data = {r_held[0], r_held[1], c, 8'h0};
                                end else begin
                                    o_job.data = {r_held[0], r_held[1], r_held[2], c};
                                end
                            end
                        end else begin
                            held_we = 1'b1;
                            n_exp   = r_exp - 2'd1;
                        end
                    end else if (!c[7]) begin
                        o_push = 1'b1;
                        o_job.data[7:0] = c;
                        priority if (c == 8'h08) begin
                            o_job.op = jse_pkg::OP_PAIR;
                            o_job.len = jse_pkg::LEN_PAIR;
                            o_job.data[7:0] = jse_pkg::CH_B;
                        end else if (c == 8'h09) begin
                            o_job.op = jse_pkg::OP_PAIR;
                            o_job.len = jse_pkg::LEN_PAIR;
                            o_job.data[7:0] = jse_pkg::CH_T;
                        end else if (c == 8'h0A) begin
                            o_job.op = jse_pkg::OP_PAIR;
                            o_job.len = jse_pkg::LEN_PAIR;
                            o_job.data[7:0] = jse_pkg::CH_N;
                        end else if (c == 8'h0C) begin
                            o_job.op = jse_pkg::OP_PAIR;
                            o_job.len = jse_pkg::LEN_PAIR;
                            o_job.data[7:0] = jse_pkg::CH_F;
                        end else if (c == 8'h0D) begin
                            o_job.op = jse_pkg::OP_PAIR;
                            o_job.len = jse_pkg::LEN_PAIR;
                            o_job.data[7:0] = jse_pkg::CH_R;
                        end else if (c < 8'h20) begin
                            o_job.op = jse_pkg::OP_HEX;
                            o_job.len = jse_pkg::LEN_HEX;
                        end else if (c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH ||
                                     (c == jse_pkg::CH_SLASH && r_esc_slashes)) begin
                            o_job.op = jse_pkg::OP_PAIR;
                            o_job.len = jse_pkg::LEN_PAIR;
                        end else begin
                            o_job.op = jse_pkg::OP_CHAR;
                        end
                    end else if ((c & jse_pkg::LEAD2_MASK) == jse_pkg::LEAD2_VAL) begin
                        held_we  = 1'b1;
                        held_idx = 2'd0;
                        n_acc    = {17'h0, c[4:0]};
                        n_len    = 3'd2;
                        n_exp    = 2'd1;
                    end else if ((c & jse_pkg::LEAD3_MASK) == jse_pkg::LEAD3_VAL) begin
                        held_we  = 1'b1;
                        held_idx = 2'd0;
                        n_acc    = {18'h0, c[3:0]};
                        n_len    = 3'd3;
                        n_exp    = 2'd2;
                    end else if ((c & jse_pkg::LEAD4_MASK) == jse_pkg::LEAD4_VAL) begin
                        held_we  = 1'b1;
                        held_idx = 2'd0;
                        n_acc    = {18'h0, c[3:0]};
                        n_len    = 3'd4;
                        n_exp    = 2'd3;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_unicode <= 1'b0;
            r_esc_slashes <= 1'b0;
            r_exp         <= 2'd0;
            r_len         <= 3'd0;
            r_acc         <= 22'h0;
        end else begin
            r_exp <= n_exp;
            r_len <= n_len;
            r_acc <= n_acc;
            if (i_cfg_we && i_cfg_index == jse_pkg::CFG_IDX_UNICODE) begin
                r_esc_unicode <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == jse_pkg::CFG_IDX_SLASHES) begin
                r_esc_slashes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held[held_idx] <= c;
        end
    end

endmodule

/* rtl/jse_queue.sv */
// Job queue between the front and back parts
`include "json_string_escaper_macros.svh"

module jse_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  jse_pkg::t_job       i_job,
    input  logic                i_pop,
    output jse_pkg::t_job       o_job,
    output jse_pkg::t_q_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    jse_pkg::t_job      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_job          = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_FULL);
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `JSE_ASSERT_IMP(a_no_overflow, i_push, !o_status.full)
    `JSE_ASSERT_IMP(a_no_underflow, i_pop, !o_status.empty)
    `JSE_ASSERT_IMP(a_count_ptrs, o_status.empty || o_status.full, r_wr == r_rd)

endmodule

/* rtl/jse_back.sv */
// Back part: expands each job into output characters
`include "json_string_escaper_macros.svh"

module jse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jse_pkg::t_job       i_job,
    input  jse_pkg::t_q_status  i_status,
    output logic                o_pop,
    input  logic                i_ready,
    output logic                o_valid,
    output jse_pkg::t_out_item  o_item
);

    jse_pkg::t_job r_job;
    logic          r_busy;
    logic [3:0]    r_pos;
    logic          is_last, adv;
    logic          second;
    logic [3:0]    jpos;
    logic [15:0]   word;
    logic [7:0]    ch;

    assign is_last = (r_pos == r_job.len - 4'd1);
    assign adv     = r_busy && i_ready;
    assign o_pop   = (!r_busy || (adv && is_last)) && !i_status.empty;

    assign second = (r_pos >= jse_pkg::LEN_HEX);
    assign jpos   = second ? r_pos - jse_pkg::LEN_HEX : r_pos;
    assign word   = (r_job.len == jse_pkg::LEN_SURR && !second) ?
                    r_job.data[31:16] : r_job.data[15:0];

    always_comb begin
        ch = r_job.data[7:0];
        unique case (r_job.op)
            jse_pkg::OP_CHAR: ch = r_job.data[7:0];
            jse_pkg::OP_PAIR: ch = (r_pos == 4'd0) ? jse_pkg::CH_BSLASH : r_job.data[7:0];
            jse_pkg::OP_RAW: begin
                unique case (r_pos[1:0])
                    2'd0: ch = r_job.data[31:24];
                    2'd1: ch = r_job.data[23:16];
                    2'd2: ch = r_job.data[15:8];
                    2'd3: ch = r_job.data[7:0];
                endcase
            end
            jse_pkg::OP_HEX: begin
                unique case (jpos[2:0])
                    3'd0:    ch = jse_pkg::CH_BSLASH;
                    3'd1:    ch = jse_pkg::CH_U;
                    3'd2:    ch = jse_pkg::hex_digit(word[15:12]);
                    3'd3:    ch = jse_pkg::hex_digit(word[11:8]);
                    3'd4:    ch = jse_pkg::hex_digit(word[7:4]);
                    default: ch = jse_pkg::hex_digit(word[3:0]);
                endcase
            end
        endcase
    end

    assign o_valid         = r_busy;
    assign o_item.out_char = ch;
    assign o_item.last     = is_last;
    assign o_item.error    = r_job.err && (r_job.op == jse_pkg::OP_CHAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 4'd0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= 4'd0;
            end else if (adv) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    `JSE_ASSERT_IMP(a_pos_in_job, r_busy, r_pos < r_job.len)
    `JSE_ASSERT_IMP(a_error_is_last, o_valid && o_item.error, o_item.last)
    `JSE_ASSERT_IMP(a_hold_on_stall, r_busy && !i_ready, ##1 (r_busy && $stable(r_pos)))

endmodule

/* rtl/json_string_escaper.sv */
// JSON string escaper: start/byte/end items in, escaped characters out
//
// Input channel (i_valid/o_ready, i_item) takes one item per cycle while o_ready
// is high: a start mark, a UTF-8 data byte or an end mark. Output channel
// (o_valid/i_ready, o_item) gives one character per cycle while i_ready is high,
// with last set on the final character caused by an item and error set on the
// end-inside-sequence item. Configuration (i_cfg_valid/o_cfg_ready) is always
// ready; index 0 sets unicode escaping, index 1 sets slash escaping. Write only
// while idle. The front part classifies each item in the cycle it is taken and
// pushes at most one job into a QUEUE_DEPTH entry queue; the back part expands
// a job at one character per cycle while i_ready is high. The first character
// is valid once its job has passed the queue and the back part's job register.
// Throughput: 1 item per cycle while each item gives at most one character and
// the receiver is ready; an item giving n characters (up to 12) keeps the back
// part busy for all n, and the queue lets the front keep accepting until it
// fills. Continuation bytes that do not close a sequence, dropped bytes and
// unused kinds give nothing. Reset clears the sequence state, queue and both
// configuration bits; no clearing pass is needed. A stalled receiver holds the
// current character and backs up into the queue, after which o_ready drops.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  jse_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output jse_pkg::t_out_item  o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic                i_cfg_data
);

    jse_pkg::t_job      push_job, head_job;
    jse_pkg::t_q_status q_status;
    logic               push, pop;

    assign o_ready     = !q_status.full;
    assign o_cfg_ready = 1'b1;

    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_valid && o_ready),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_job       (push_job)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    jse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_status (q_status),
        .o_pop    (pop),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

endmodule

/* tb/testbench.sv */
// Testbench for json_string_escaper: directed table, then random strings checked against a predictor
`timescale 1ns / 1ps

module testbench;
    import jse_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         STALL_LIMIT   = 600;
    localparam int         CHUNK_ITEMS   = 64;
    localparam int         DIR_ROWS      = 27;
    localparam int         DIR_SPLIT     = 19;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       typed;
        logic       err;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{KIND_START,  8'h00, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h00, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h08, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h09, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h0A, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h0C, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h0D, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h1F, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h22, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h5C, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h2F, 1'b1, 1'b0},
        '{KIND_BYTE,   8'h7F, 1'b0, 1'b0},
        '{KIND_BYTE,   8'h80, 1'b0, 1'b0},
        '{KIND_BYTE,   8'hFF, 1'b0, 1'b0},
        '{KIND_BYTE,   8'hC3, 1'b0, 1'b0},
        '{KIND_BYTE,   8'hA9, 1'b0, 1'b0},
        '{KIND_UNUSED, 8'hFF, 1'b0, 1'b0},
        '{KIND_BYTE,   8'hE2, 1'b0, 1'b0},
        '{KIND_END,    8'h00, 1'b1, 1'b1},
        '{KIND_BYTE,   8'h2F, 1'b1, 1'b0},
        '{KIND_BYTE,   8'hF0, 1'b0, 1'b0},
        '{KIND_BYTE,   8'h80, 1'b0, 1'b0},
        '{KIND_BYTE,   8'h80, 1'b0, 1'b0},
        '{KIND_BYTE,   8'h80, 1'b0, 1'b0},
        '{KIND_BYTE,   8'hE2, 1'b0, 1'b0},
        '{KIND_START,  8'hFF, 1'b1, 1'b0},
        '{KIND_END,    8'hFF, 1'b1, 1'b0}
    };

    string dir_text [DIR_ROWS] = '{
        "\"", "\\u0000", "\\b", "\\t", "\\n", "\\f", "\\r", "\\u001F", "\\\"", "\\\\", "/",
        "", "", "", "", "", "", "", "",
        "\\/", "", "", "", "", "", "\"", "\""
    };

    // {escape_unicode, escape_slashes} per random chunk
    localparam logic [1:0] CHUNK_CFG [6] = '{2'b10, 2'b01, 2'b11, 2'b00, 2'b10, 2'b01};
    localparam logic [7:0] JSON_SPECIALS [3] = '{CH_QUOTE, CH_BSLASH, CH_SLASH};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    t_in_item   i_item      = '0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    t_out_item  o_item;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic       i_cfg_data  = 1'b0;

    json_string_escaper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    int send_idle = 27;
    int recv_idle = 55;
    int items_sent;
    int chars_checked;
    int err_ends;
    int mismatches;
    int stall_cycles;

    logic        opt_unicode;
    logic        opt_slashes;
    logic [1:0]  seq_left;
    logic [2:0]  seq_len;
    logic [21:0] cp_acc;
    logic [7:0]  held [3];
    logic [7:0]  burst_chars [$];
    logic        burst_err;
    t_out_item   want_chars [$];
    t_out_item   head_char;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? {4'h3, v} : 8'h41 + {4'h0, v} - 8'd10;
    endfunction

    function automatic void emit(input logic [7:0] c);
        burst_chars.push_back(c);
    endfunction

    function automatic void emit_uesc(input logic [15:0] v);
        int k;
        emit(CH_BSLASH);
        emit(CH_U);
        for (k = 3; k >= 0; k--) emit(hex_char(v[k*4 +: 4]));
    endfunction

    function automatic void clear_seq();
        seq_left = 2'd0;
        seq_len  = 3'd0;
        cp_acc   = '0;
    endfunction

    function automatic void open_seq(input logic [7:0] c, input logic [2:0] len,
                                     input logic [21:0] bits);
        held[0]  = c;
        cp_acc   = bits;
        seq_len  = len;
        seq_left = 2'(len - 3'd1);
    endfunction

    function automatic void escape_ascii(input logic [7:0] c);
        logic [7:0] e;
        case (c)
            8'h08: e = CH_B;
            8'h09: e = CH_T;
            8'h0A: e = CH_N;
            8'h0C: e = CH_F;
            8'h0D: e = CH_R;
            CH_QUOTE, CH_BSLASH, CH_SLASH: e = c;
            default: e = (c < 8'h20) ? CH_U : CH_NUL;
        endcase
        if (e == CH_NUL) begin
            emit(c);
        end else if (e == CH_U) begin
            emit_uesc({8'h00, c});
        end else begin
            if (c != CH_SLASH || opt_slashes) emit(CH_BSLASH);
            emit(e);
        end
    endfunction

    function automatic void close_seq(input logic [7:0] c);
        logic [31:0] v;
        logic [31:0] hi;
        logic [31:0] lo;
        int k;
        if (opt_unicode) begin
            if (seq_len == 3'd4) begin
                // overlong forms wrap here, same masks apply
                v  = {10'd0, cp_acc} - 32'h0001_0000;
                hi = ((v & 32'h000F_FC00) >> 10) + 32'hD800;
                lo = (v & 32'h0000_03FF) + 32'hDC00;
                emit_uesc(hi[15:0]);
                emit_uesc(lo[15:0]);
            end else begin
                emit_uesc(cp_acc[15:0]);
            end
        end else begin
            for (k = 0; k < int'(seq_len) - 1 && k < 3; k++) emit(held[k]);
            emit(c);
        end
        clear_seq();
    endfunction

    function automatic void escape_item(input t_in_item it);
        logic [7:0] c;
        logic [2:0] pos;
        c = it.byte_value;
        burst_chars = {};
        burst_err = 1'b0;
        case (it.kind)
            KIND_START: begin
                clear_seq();
                emit(CH_QUOTE);
            end
            KIND_BYTE: begin
                if (seq_left != 2'd0) begin
                    pos = seq_len - {1'b0, seq_left};
                    cp_acc = {cp_acc[15:0], c[5:0]};
                    if (seq_left == 2'd1) begin
                        close_seq(c);
                    end else begin
                        if (pos < 3'd3) held[pos] = c;
                        seq_left = seq_left - 2'd1;
                    end
                end else if (!c[7]) begin
                    escape_ascii(c);
                end else if ((c & LEAD2_MASK) == LEAD2_VAL) begin
                    open_seq(c, 3'd2, {17'd0, c[4:0]});
                end else if ((c & LEAD3_MASK) == LEAD3_VAL) begin
                    open_seq(c, 3'd3, {18'd0, c[3:0]});
                end else if ((c & LEAD4_MASK) == LEAD4_VAL) begin
                    open_seq(c, 3'd4, {18'd0, c[3:0]});
                end
            end
            KIND_END: begin
                if (seq_left != 2'd0) begin
                    clear_seq();
                    burst_err = 1'b1;
                end else begin
                    emit(CH_QUOTE);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_burst();
        int k;
        if (burst_err) begin
            want_chars.push_back('{out_char: CH_NUL, last: 1'b1, error: 1'b1});
        end else begin
            for (k = 0; k < burst_chars.size(); k++) begin
                want_chars.push_back('{out_char: burst_chars[k],
                                       last: (k == burst_chars.size() - 1),
                                       error: 1'b0});
            end
        end
    endfunction

    task automatic send_item(input t_in_item it, input logic typed, input logic typed_err,
                             input string text);
        int k;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        escape_item(it);
        if (typed) begin
            burst_err = typed_err;
            burst_chars = {};
            for (k = 0; k < text.len(); k++) burst_chars.push_back(text[k]);
        end
        queue_burst();
        if (it.kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic feed(input logic [1:0] kind, input logic [7:0] value);
        t_in_item it;
        it.kind = kind;
        it.byte_value = value;
        send_item(it, 1'b0, 1'b0, "");
    endtask

    task automatic feed_utf8(input int len, input logic cut);
        logic [7:0] lead;
        int conts;
        case (len)
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        conts = cut ? $urandom_range(len - 2, 0) : len - 1;
        feed(KIND_BYTE, lead);
        repeat (conts) begin
            if ($urandom_range(9) == 0) feed(KIND_BYTE, 8'($urandom));
            else feed(KIND_BYTE, {2'b10, 6'($urandom)});
        end
    endtask

    task automatic feed_random_string();
        int pick;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1))
                feed(($urandom_range(2) == 0) ? KIND_END : KIND_BYTE, 8'($urandom));
        end
        feed(KIND_START, 8'($urandom));
        repeat ($urandom_range(8, 1)) begin
            pick = $urandom_range(99);
            if (pick < 28) feed(KIND_BYTE, 8'($urandom_range(8'h7F, 8'h20)));
            else if (pick < 40) feed(KIND_BYTE, 8'($urandom_range(8'h1F, 8'h00)));
            else if (pick < 48) feed(KIND_BYTE, JSON_SPECIALS[$urandom_range(2)]);
            else if (pick < 58) feed_utf8(2, 1'b0);
            else if (pick < 68) feed_utf8(3, 1'b0);
            else if (pick < 80) feed_utf8(4, 1'b0);
            else if (pick < 85) feed(KIND_BYTE, $urandom_range(1) ?
                                     8'($urandom_range(8'hBF, 8'h80)) :
                                     8'($urandom_range(8'hFF, 8'hF8)));
            else if (pick < 90) feed_utf8($urandom_range(4, 2), 1'b1);
            else if (pick < 93) feed(KIND_UNUSED, 8'($urandom));
            else if (pick < 96) feed(KIND_START, 8'($urandom));
            else feed(KIND_BYTE, 8'($urandom));
        end
        if ($urandom_range(7) == 0) feed_utf8($urandom_range(4, 2), 1'b1);
        feed(KIND_END, 8'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (want_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic unicode_on, input logic slashes_on);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_UNICODE;
        i_cfg_data  <= unicode_on;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        opt_unicode = unicode_on;
        i_cfg_index <= CFG_IDX_SLASHES;
        i_cfg_data  <= slashes_on;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        opt_slashes = slashes_on;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            chars_checked++;
            if (o_item.error) err_ends++;
            if (want_chars.size() == 0) begin
                $error("unexpected item: out_char %02h last %0b error %0b",
                       o_item.out_char, o_item.last, o_item.error);
                mismatches++;
            end else begin
                head_char = want_chars.pop_front();
                if (o_item.out_char !== head_char.out_char) begin
                    $error("out_char: expected %02h, got %02h",
                           head_char.out_char, o_item.out_char);
                    mismatches++;
                end
                if (o_item.last !== head_char.last) begin
                    $error("last: expected %0b, got %0b", head_char.last, o_item.last);
                    mismatches++;
                end
                if (o_item.error !== head_char.error) begin
                    $error("error: expected %0b, got %0b", head_char.error, o_item.error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int k;
        int chunk;
        opt_unicode = 1'b0;
        opt_slashes = 1'b0;
        clear_seq();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(1'b0, 1'b0);
        for (k = 0; k < DIR_ROWS; k++) begin
            if (k == DIR_SPLIT) begin
                drain();
                set_config(1'b1, 1'b1);
            end
            send_item('{kind: DIR_TABLE[k].kind, byte_value: DIR_TABLE[k].value},
                      DIR_TABLE[k].typed, DIR_TABLE[k].err, dir_text[k]);
        end
        for (chunk = 0; chunk < 6; chunk++) begin
            drain();
            if (chunk == 2) begin
                send_idle = 55;
                recv_idle = 27;
            end else if (chunk == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_config(CHUNK_CFG[chunk][1], CHUNK_CFG[chunk][0]);
            while (items_sent < DIR_ROWS + (chunk + 1) * CHUNK_ITEMS) feed_random_string();
        end
        drain();
        $display("run: %0d items in, %0d characters out, %0d strings cut inside a sequence",
                 items_sent, chars_checked, err_ends);
        $display("run: all four option settings, sender and receiver stalls both ways");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/json_string_escaper.sv
tb/testbench.sv
